// File: rtl/ar_pkg.sv
// Shared types and constants for the Aroon oscillator block.
`default_nettype none

package ar_pkg;

  localparam int PERIOD_W   = 6;
  localparam int AGE_W      = 6;
  localparam int PCT_W      = 15;
  localparam int OSC_W      = 16;
  localparam int IN_PRICE_W = 32;
  localparam int QUOT_W     = 15;
  localparam int DIVIDEND_W = 21;
  localparam int REM_W      = PERIOD_W;

  localparam logic [PERIOD_W-1:0] PERIOD_RESET = 6'd14;
  localparam logic [QUOT_W-1:0]   FULL_SCALE   = 15'd25600;

  typedef struct packed {
    logic [IN_PRICE_W-1:0] high_price;
    logic [IN_PRICE_W-1:0] low_price;
    logic                  bar_missing;
  } ar_in_t;

  typedef struct packed {
    logic                    result_valid;
    logic [PCT_W-1:0]        up_pct;
    logic [PCT_W-1:0]        down_pct;
    logic signed [OSC_W-1:0] osc_pct;
    logic [AGE_W-1:0]        bars_since_high;
    logic [AGE_W-1:0]        bars_since_low;
  } ar_out_t;

  // Control broadcast to every cell of the bar chain
  typedef struct packed {
    logic shift;
    logic rotate;
  } ar_chain_ctl_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_SCAN,
    S_MUL,
    S_START,
    S_DIV,
    S_OUT
  } ar_state_t;

endpackage

`default_nettype wire

// File: rtl/ar_cell.sv
// One cell of the bar chain: holds one bar, shifts in from the newer side or rotates.
`default_nettype none

module ar_cell
  import ar_pkg::*;
#(
  parameter int PRICE_BITS = 32
) (
  input  wire logic                  clk,
  input  wire ar_chain_ctl_t         ctl,
  input  wire logic [PRICE_BITS-1:0] prev_high,
  input  wire logic [PRICE_BITS-1:0] prev_low,
  input  wire logic                  prev_missing,
  input  wire logic [PRICE_BITS-1:0] next_high,
  input  wire logic [PRICE_BITS-1:0] next_low,
  input  wire logic                  next_missing,
  output logic      [PRICE_BITS-1:0] high,
  output logic      [PRICE_BITS-1:0] low,
  output logic                       missing
);

  // Take the newer bar on a shift, the older bar on a rotate, else hold
  always_ff @(posedge clk) begin
    if (ctl.shift) begin
      high    <= prev_high;
      low     <= prev_low;
      missing <= prev_missing;
    end else if (ctl.rotate) begin
      high    <= next_high;
      low     <= next_low;
      missing <= next_missing;
    end
  end

endmodule

`default_nettype wire

// File: rtl/ar_div.sv
// Restoring divider, one quotient bit per cycle, for the percentage scaling.
`default_nettype none

module ar_div
  import ar_pkg::*;
(
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  start,
  input  wire logic [DIVIDEND_W-1:0] dividend,
  input  wire logic [PERIOD_W-1:0]   divisor,
  output logic      [QUOT_W-1:0]     quotient,
  output logic                       done
);

  logic [REM_W-1:0]  rem;
  logic [QUOT_W-1:0] dvd_lo;
  logic [3:0]        cnt;
  logic              busy;
  logic [REM_W:0]    trial;
  logic              fits;

  // Bring down the next dividend bit and try the subtract
  assign trial = {rem, dvd_lo[QUOT_W-1]};
  assign fits  = trial >= {1'b0, divisor};

  // Sequence the quotient bits
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= 4'(QUOT_W);
      end else if (busy) begin
        cnt <= cnt - 4'd1;
        if (cnt == 4'd1) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  // Datapath: the top bits are already below the divisor since the quotient fits
  always_ff @(posedge clk) begin
    if (start) begin
      rem      <= dividend[DIVIDEND_W-1:QUOT_W];
      dvd_lo   <= dividend[QUOT_W-1:0];
      quotient <= '0;
    end else if (busy) begin
      dvd_lo <= {dvd_lo[QUOT_W-2:0], 1'b0};
      if (fits) begin
        rem      <= REM_W'(trial - {1'b0, divisor});
        quotient <= {quotient[QUOT_W-2:0], 1'b1};
      end else begin
        rem      <= trial[REM_W-1:0];
        quotient <= {quotient[QUOT_W-2:0], 1'b0};
      end
    end
  end

endmodule

`default_nettype wire

// File: rtl/aroon_oscillator.sv
// Top level: Aroon up, down and oscillator over a chain of stored price bars.
// One item at a time: the input stays closed while the full-chain rotation and the
//   15-step dividers run, and until the result is loaded.
// A finished result waits in the output register while the next item is taken.
// Reset: synchronous, clears control, bar count, scan position and sets period to 14.
`default_nettype none

module aroon_oscillator
  import ar_pkg::*;
#(
  parameter int WINDOW_DEPTH = 64,
  parameter int PRICE_BITS   = 32
) (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic                bar_valid,
  output logic                     bar_ready,
  input  wire ar_in_t              bar_item,
  output logic                     res_valid,
  input  wire logic                res_ready,
  output ar_out_t                  res_item,
  input  wire logic                cfg_we,
  input  wire logic [PERIOD_W-1:0] cfg_data
);

  localparam int SCAN_W = $clog2(WINDOW_DEPTH);
  localparam int SEEN_W = $clog2(WINDOW_DEPTH + 1);
  localparam int WIN_W  = (SEEN_W > PERIOD_W + 1) ? SEEN_W : PERIOD_W + 1;

  ar_state_t state, state_next;

  logic [PERIOD_W-1:0] window_period;
  logic [PERIOD_W-1:0] period_eff;
  logic [PERIOD_W-1:0] period_q;
  logic [WIN_W-1:0]    win_raw;
  logic [WIN_W-1:0]    window_now;
  logic [WIN_W-1:0]    window_q;
  logic [SEEN_W-1:0]   bars_seen;
  logic [SEEN_W-1:0]   seen_next;
  logic                enough;
  logic                res_ok;
  logic [SCAN_W-1:0]   cnt;
  logic                scan_last;

  logic                accept;
  logic                cmp_en;
  logic                mul_en;
  logic                div_start;
  logic                load;
  ar_chain_ctl_t       chain_ctl;

  logic [PRICE_BITS-1:0] new_high;
  logic [PRICE_BITS-1:0] new_low;
  logic [PRICE_BITS-1:0] cell_high    [WINDOW_DEPTH];
  logic [PRICE_BITS-1:0] cell_low     [WINDOW_DEPTH];
  logic                  cell_missing [WINDOW_DEPTH];

  logic                  found;
  logic [PRICE_BITS-1:0] best_high;
  logic [PRICE_BITS-1:0] best_low;
  logic [AGE_W-1:0]      age_high;
  logic [AGE_W-1:0]      age_low;
  logic [DIVIDEND_W-1:0] dvd_high;
  logic [DIVIDEND_W-1:0] dvd_low;
  logic [QUOT_W-1:0]     quot_high;
  logic [QUOT_W-1:0]     quot_low;
  logic                  done_high;
  logic                  done_low;

  // Configuration register
  always_ff @(posedge clk) begin
    if (rst) begin
      window_period <= PERIOD_RESET;
    end else if (cfg_we) begin
      window_period <= cfg_data;
    end
  end

  // Effective period and clipped window length
  assign period_eff = (window_period == '0) ? PERIOD_W'(1) : window_period;
  assign win_raw    = WIN_W'(period_eff) + WIN_W'(1);
  assign window_now = (win_raw > WIN_W'(WINDOW_DEPTH)) ? WIN_W'(WINDOW_DEPTH) : win_raw;
  assign seen_next  = (bars_seen == SEEN_W'(WINDOW_DEPTH)) ? bars_seen
                                                           : bars_seen + SEEN_W'(1);
  assign enough     = WIN_W'(seen_next) >= window_now;
  assign accept     = bar_valid && bar_ready;
  assign scan_last  = cnt == SCAN_W'(WINDOW_DEPTH - 1);

  // Latch per-item settings and count bars
  always_ff @(posedge clk) begin
    if (rst) begin
      bars_seen <= '0;
      res_ok    <= 1'b0;
    end else if (accept) begin
      bars_seen <= seen_next;
      res_ok    <= enough;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      period_q <= period_eff;
      window_q <= window_now;
    end
  end

  // Scan position counter: equals the age of the bar in the head cell
  always_ff @(posedge clk) begin
    if (rst) begin
      cnt <= '0;
    end else if (accept) begin
      cnt <= '0;
    end else if (chain_ctl.rotate && !scan_last) begin
      cnt <= cnt + SCAN_W'(1);
    end
  end

  // Next state
  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (accept) begin
          state_next = enough ? S_SCAN : S_OUT;
        end
      end
      S_SCAN: begin
        if (scan_last) begin
          state_next = S_MUL;
        end
      end
      S_MUL:   state_next = S_START;
      S_START: state_next = S_DIV;
      S_DIV: begin
        if (done_high && done_low) begin
          state_next = S_OUT;
        end
      end
      S_OUT: begin
        if (!res_valid || res_ready) begin
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  // Control outputs
  always_comb begin
    bar_ready        = 1'b0;
    chain_ctl.shift  = 1'b0;
    chain_ctl.rotate = 1'b0;
    mul_en           = 1'b0;
    div_start        = 1'b0;
    load             = 1'b0;
    unique case (state)
      S_IDLE: begin
        bar_ready       = 1'b1;
        chain_ctl.shift = bar_valid;
      end
      S_SCAN:  chain_ctl.rotate = 1'b1;
      S_MUL:   mul_en = 1'b1;
      S_START: div_start = 1'b1;
      S_DIV:   ;
      S_OUT:   load = !res_valid || res_ready;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Bar chain: newest bar at cell 0, rotation walks older bars into cell 0
  assign new_high = PRICE_BITS'(bar_item.high_price);
  assign new_low  = PRICE_BITS'(bar_item.low_price);

  for (genvar k = 0; k < WINDOW_DEPTH; k++) begin : g_chain
    logic [PRICE_BITS-1:0] src_high;
    logic [PRICE_BITS-1:0] src_low;
    logic                  src_missing;

    if (k == 0) begin : g_head
      assign src_high    = new_high;
      assign src_low     = new_low;
      assign src_missing = bar_item.bar_missing;
    end else begin : g_body
      assign src_high    = cell_high[k-1];
      assign src_low     = cell_low[k-1];
      assign src_missing = cell_missing[k-1];
    end

    ar_cell #(
      .PRICE_BITS(PRICE_BITS)
    ) u_cell (
      .clk          (clk),
      .ctl          (chain_ctl),
      .prev_high    (src_high),
      .prev_low     (src_low),
      .prev_missing (src_missing),
      .next_high    (cell_high[(k + 1) % WINDOW_DEPTH]),
      .next_low     (cell_low[(k + 1) % WINDOW_DEPTH]),
      .next_missing (cell_missing[(k + 1) % WINDOW_DEPTH]),
      .high         (cell_high[k]),
      .low          (cell_low[k]),
      .missing      (cell_missing[k])
    );
  end

  // Track extremes at the head cell; >= and <= let older bars win ties
  assign cmp_en = (state == S_SCAN) && (WIN_W'(cnt) < window_q) && !cell_missing[0];

  always_ff @(posedge clk) begin
    if (rst) begin
      found <= 1'b0;
    end else if (accept) begin
      found <= 1'b0;
    end else if (cmp_en) begin
      found <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      age_high <= '0;
      age_low  <= '0;
    end else if (cmp_en) begin
      if (!found || cell_high[0] >= best_high) begin
        best_high <= cell_high[0];
        age_high  <= AGE_W'(cnt);
      end
      if (!found || cell_low[0] <= best_low) begin
        best_low <= cell_low[0];
        age_low  <= AGE_W'(cnt);
      end
    end
  end

  // Scale the spans by full scale before dividing by the period
  always_ff @(posedge clk) begin
    if (mul_en) begin
      dvd_high <= DIVIDEND_W'(period_q - age_high) * DIVIDEND_W'(FULL_SCALE);
      dvd_low  <= DIVIDEND_W'(period_q - age_low) * DIVIDEND_W'(FULL_SCALE);
    end
  end

  ar_div u_div_high (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (dvd_high),
    .divisor  (period_q),
    .quotient (quot_high),
    .done     (done_high)
  );

  ar_div u_div_low (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (dvd_low),
    .divisor  (period_q),
    .quotient (quot_low),
    .done     (done_low)
  );

  // Output register: hold the item until taken
  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (load) begin
      res_valid <= 1'b1;
    end else if (res_ready) begin
      res_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      if (res_ok) begin
        res_item.result_valid    <= 1'b1;
        res_item.up_pct          <= quot_high;
        res_item.down_pct        <= quot_low;
        res_item.osc_pct         <= OSC_W'(quot_high) - OSC_W'(quot_low);
        res_item.bars_since_high <= age_high;
        res_item.bars_since_low  <= age_low;
      end else begin
        res_item <= '0;
      end
    end
  end

endmodule

`default_nettype wire

// File: rtl/ar_checker.sv
// Port-level checks for the Aroon oscillator, bound to the top level.
`default_nettype none

module ar_checker
  import ar_pkg::*;
(
  input wire logic    clk,
  input wire logic    rst,
  input wire logic    bar_valid,
  input wire logic    bar_ready,
  input wire logic    res_valid,
  input wire logic    res_ready,
  input wire ar_out_t res_item
);

  // A stalled result holds
  a_res_hold: assert property (@(posedge clk) disable iff (rst)
    res_valid && !res_ready |=> res_valid && $stable(res_item))
    else $error("result item changed while stalled");

  // One item at a time: input closes after an accept
  a_one_item: assert property (@(posedge clk) disable iff (rst)
    bar_valid && bar_ready |=> !bar_ready)
    else $error("input accepted again while an item is in flight");

  // Warm-up results carry zeros
  a_warmup_zero: assert property (@(posedge clk) disable iff (rst)
    res_valid && !res_item.result_valid |->
      res_item.up_pct == '0 && res_item.down_pct == '0 &&
      res_item.osc_pct == '0 && res_item.bars_since_high == '0 &&
      res_item.bars_since_low == '0)
    else $error("warm-up result not zero");

  // Oscillator is up minus down, both in range
  a_osc_diff: assert property (@(posedge clk) disable iff (rst)
    res_valid |->
      res_item.osc_pct == OSC_W'(res_item.up_pct) - OSC_W'(res_item.down_pct) &&
      res_item.up_pct <= FULL_SCALE && res_item.down_pct <= FULL_SCALE)
    else $error("oscillator inconsistent with up and down");

  // Reset empties the output
  a_reset_empty: assert property (@(posedge clk)
    rst |=> !res_valid)
    else $error("result valid right after reset");

endmodule

bind aroon_oscillator ar_checker u_ar_checker (.*);

`default_nettype wire
